// ===== rtl/core/krt_pkg.sv =====
package krt_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int KEY_W        = 32;
    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 3;
    localparam int COUNT_W      = 8;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd4;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [DATA_W-1:0]       data;
    } record_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

// ===== rtl/core/krt_store.sv =====
module krt_store #(
    parameter int CAPACITY = 128,
    parameter int IDX_W    = 7
) (
    input  logic              clk,
    input  krt_pkg::mem_ctl_t mem_ctl,
    input  logic [IDX_W-1:0]  wr_addr,
    input  krt_pkg::record_t  wr_data,
    input  logic [IDX_W-1:0]  rd_addr,
    output krt_pkg::record_t  rd_data
);
    import krt_pkg::*;

    record_t mem [CAPACITY];
    record_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/krt_ctrl.sv =====
module krt_ctrl #(
    parameter int CAPACITY = 128,
    parameter int IDX_W    = 7,
    parameter int CNT_W    = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           action,
    input  logic signed [krt_pkg::KEY_W-1:0] key,
    input  logic [krt_pkg::DATA_W-1:0]     entry_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [krt_pkg::STATUS_W-1:0]   status,
    output logic [krt_pkg::COUNT_W-1:0]    entry_count,
    output krt_pkg::mem_ctl_t              mem_ctl,
    output logic [IDX_W-1:0]               wr_addr,
    output krt_pkg::record_t               wr_data,
    output logic [IDX_W-1:0]               rd_addr,
    input  krt_pkg::record_t               rd_data
);
    import krt_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        issue_reg, issue_next;
    logic                    pend_reg, pend_next;
    logic [IDX_W-1:0]        pend_idx_reg, pend_idx_next;
    logic                    op_reg, op_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [DATA_W-1:0]       data_reg, data_next;
    logic [STATUS_W-1:0]     res_reg, res_next;
    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [COUNT_W-1:0]      entry_count_reg, entry_count_next;
    logic                    more;

    assign more = (issue_reg < count_reg);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        issue_next       = issue_reg;
        pend_next        = pend_reg;
        pend_idx_next    = pend_idx_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        data_next        = data_reg;
        res_next         = res_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        entry_count_next = entry_count_reg;
        mem_ctl          = '0;
        wr_addr          = count_reg[IDX_W-1:0];
        wr_data          = '{key: key_reg, data: data_reg};
        rd_addr          = issue_reg[IDX_W-1:0];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = action;
                    key_next   = key;
                    data_next  = entry_data;
                    issue_next = '0;
                    pend_next  = 1'b0;
                    if (action == ACT_INSERT && count_reg >= CNT_W'(CAPACITY))
                    begin
                        res_next   = ST_FULL;
                        state_next = S_FINISH;
                    end
                    else if (count_reg == '0)
                    begin
                        if (action == ACT_INSERT)
                        begin
                            mem_ctl.wr_en = 1'b1;
                            wr_addr       = '0;
                            wr_data       = '{key: key, data: entry_data};
                            res_next      = ST_INSERTED;
                        end
                        else
                        begin
                            res_next = ST_NOTFOUND;
                        end
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                mem_ctl.rd_en = more;
                if (more)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                pend_next     = more;
                pend_idx_next = issue_reg[IDX_W-1:0];
                if (pend_reg && rd_data.key == key_reg)
                begin
                    if (op_reg == ACT_INSERT)
                    begin
                        res_next   = ST_DUPLICATE;
                        pend_next  = 1'b0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        // restart reads just past the hit
                        issue_next = CNT_W'(pend_idx_reg) + 1'b1;
                        pend_next  = 1'b0;
                        state_next = S_SHIFT;
                    end
                end
                else if (!pend_reg && !more)
                begin
                    if (op_reg == ACT_INSERT)
                    begin
                        mem_ctl.wr_en = 1'b1;
                        res_next      = ST_INSERTED;
                    end
                    else
                    begin
                        res_next = ST_NOTFOUND;
                    end
                    state_next = S_FINISH;
                end
            end
            S_SHIFT:
            begin
                // read entry j+2 while writing entry j, never the same address
                mem_ctl.rd_en = more;
                if (more)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                pend_next     = more;
                pend_idx_next = issue_reg[IDX_W-1:0];
                if (pend_reg)
                begin
                    mem_ctl.wr_en = 1'b1;
                    wr_addr       = pend_idx_reg - 1'b1;
                    wr_data       = rd_data;
                end
                else if (!more)
                begin
                    res_next   = ST_REMOVED;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    if (res_reg == ST_INSERTED)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else if (res_reg == ST_REMOVED)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    out_valid_next   = 1'b1;
                    status_next      = res_reg;
                    entry_count_next = COUNT_W'(count_next);
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg    <= pend_idx_next;
        op_reg          <= op_next;
        key_reg         <= key_next;
        data_reg        <= data_next;
        res_reg         <= res_next;
        status_reg      <= status_next;
        entry_count_reg <= entry_count_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("record count above capacity");

    a_count_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (out_valid_reg && (status_reg == ST_INSERTED || status_reg == ST_REMOVED)))
        else $error("count changed without an insert or remove result");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctl.wr_en && mem_ctl.rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write hit the same entry");

    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.wr_en |-> (CNT_W'(wr_addr) <= count_reg))
        else $error("write beyond the record count");

    a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_SEARCH || state_reg == S_SHIFT))
        else $error("read pending outside search or shift");
`endif

endmodule

// ===== rtl/core/keyed_record_table_unit.sv =====
// channel   direction  handshake            payload
// request   in         in_valid / in_stall  action, key, entry_data
// result    out        out_valid/ out_stall status, entry_count
//
// one request at a time; the search and the remove shift use one memory read port,
// stepping one entry a cycle
// search and shift are pipelined over the registered memory read
// rst_n clears the record count and the control state; the record memory is not cleared
// a finished result waits in the output register while out_stall is high

module keyed_record_table_unit #(
    parameter int CAPACITY = krt_pkg::CAPACITY_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             action,
    input  logic signed [krt_pkg::KEY_W-1:0] key,
    input  logic [krt_pkg::DATA_W-1:0]       entry_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [krt_pkg::STATUS_W-1:0]     status,
    output logic [krt_pkg::COUNT_W-1:0]      entry_count
);
    import krt_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    mem_ctl_t         mem_ctl;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    record_t          wr_data;
    record_t          rd_data;

    krt_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .key         (key),
        .entry_data  (entry_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .entry_count (entry_count),
        .mem_ctl     (mem_ctl),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    krt_store #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_store (
        .clk     (clk),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
